// ===== rtl/float_to_fixed_decimal_text_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the decimal text unit.
// ----------------------------------------------------------------------------
`ifndef FLOAT_TO_FIXED_DECIMAL_TEXT_UNIT_ASSERT_SVH
`define FLOAT_TO_FIXED_DECIMAL_TEXT_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define F2FD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");
// next-cycle implication
`define F2FD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define F2FD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define F2FD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/f2fd_pkg.sv =====
// ----------------------------------------------------------------------------
// f2fd_pkg
// Types and constants of the float to fixed decimal text unit.
// ----------------------------------------------------------------------------
package f2fd_pkg;

  localparam int IPART_W   = 31;
  localparam int FRAC_BITS = 48;
  localparam int WIDE_W    = IPART_W + FRAC_BITS;
  localparam int DIGITS    = 10;
  localparam int DIG_IDX_W = 4;
  localparam int MANT_W    = 24;

  localparam logic [7:0] ALIGN_BIAS = 8'd102;
  localparam logic [7:0] SAT_EXP    = 8'd158;

  localparam logic [IPART_W-1:0] SAT_INTEGER = {IPART_W{1'b1}};

  localparam logic [2:0] FRACTION_DIGITS_RESET = 3'd4;
  localparam logic [3:0] MAX_FRACTION_DIGITS   = 4'd6;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_INT,
    ST_POINT,
    ST_FRAC
  } f2fd_state_t;

  typedef struct packed {
    logic                 done;
    logic [DIG_IDX_W-1:0] top_idx;
  } f2fd_bcd_status_t;

endpackage

// ===== rtl/float_to_fixed_decimal_text_unit.sv =====
// ----------------------------------------------------------------------------
// float_to_fixed_decimal_text_unit
// Formats an IEEE single-precision value as fixed-point decimal ASCII text.
//
//   channel  handshake              payload
//   in       start / busy           in_value_bits
//   out      out_valid (strobe)     out_character, out_last, out_overflow
//   cfg      cfg_valid / cfg_ready  cfg_fraction_digits
//
// Each number runs through bit-serial BCD conversion of the integer part,
// then the pick of the leading digit, then its characters (at most 18).
// Characters leave one per cycle; the next start is taken on the cycle the
// last character is shown. Synchronous active-low reset; fraction_digits
// resets to 4. The receiver cannot stall.
// ----------------------------------------------------------------------------
`include "float_to_fixed_decimal_text_unit_assert.svh"

module float_to_fixed_decimal_text_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_value_bits,
  output logic        out_valid,
  output logic [7:0]  out_character,
  output logic        out_last,
  output logic        out_overflow,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_fraction_digits
);
  import f2fd_pkg::*;

  f2fd_state_t          state_r, state_nxt;
  logic [2:0]           frac_digits_r;
  logic [2:0]           d_r, d_eff;
  logic                 neg_r, ovf_r;
  logic [DIG_IDX_W-1:0] idx_r, idx_nxt;
  logic [2:0]           cnt_r, cnt_nxt;
  logic [2:0]           cnt_inc;
  logic                 out_valid_r, valid_nxt;
  logic [7:0]           out_char_r, char_nxt;
  logic                 out_last_r, last_nxt;
  logic                 out_ovf_r;

  logic                 accept;
  logic                 bcd_load, frac_load, frac_step;
  logic [3:0]           int_digit, frac_digit;
  f2fd_bcd_status_t     bcd_status;

  logic [7:0]           bexp;
  logic [22:0]          man;
  logic [MANT_W-1:0]    mant;
  logic [7:0]           exp_eff;
  logic                 sat, tiny, is_nan, is_zero;
  logic [5:0]           shamt;
  logic [WIDE_W-1:0]    wide;
  logic [IPART_W-1:0]   ipart;
  logic [FRAC_BITS-1:0] fpart;

  // Align the significand as integer part plus FRAC_BITS fraction bits
  assign bexp    = in_value_bits[30:23];
  assign man     = in_value_bits[22:0];
  assign mant    = {(bexp != 8'd0), man};
  assign exp_eff = (bexp == 8'd0) ? 8'd1 : bexp;
  assign sat     = (bexp >= SAT_EXP);
  assign tiny    = (exp_eff < ALIGN_BIAS);
  assign is_nan  = (bexp == 8'hFF) && (man != 23'd0);
  assign is_zero = (bexp == 8'd0) && (man == 23'd0);
  assign shamt   = 6'(exp_eff - ALIGN_BIAS);
  assign wide    = WIDE_W'(mant) << shamt;
  assign ipart   = sat ? SAT_INTEGER : (tiny ? '0 : wide[WIDE_W-1:FRAC_BITS]);
  assign fpart   = (sat || tiny) ? '0 : wide[FRAC_BITS-1:0];

  assign d_eff = ({1'b0, frac_digits_r} > MAX_FRACTION_DIGITS) ?
                 MAX_FRACTION_DIGITS[2:0] : frac_digits_r;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = !busy;
  assign cnt_inc   = 3'(cnt_r + 3'd1);

  f2fd_bcd_conv u_bcd (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (bcd_load),
    .bin_in (ipart),
    .sel    (idx_r),
    .digit  (int_digit),
    .status (bcd_status)
  );

  f2fd_frac_gen u_frac (
    .clk     (clk),
    .load    (frac_load),
    .step    (frac_step),
    .frac_in (fpart),
    .digit   (frac_digit)
  );

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    valid_nxt = 1'b0;
    char_nxt  = CH_ZERO;
    last_nxt  = 1'b0;
    bcd_load  = 1'b0;
    frac_load = 1'b0;
    frac_step = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          bcd_load  = 1'b1;
          frac_load = 1'b1;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (bcd_status.done) begin
          idx_nxt   = bcd_status.top_idx;
          state_nxt = neg_r ? ST_SIGN : ST_INT;
        end
      end
      ST_SIGN: begin
        valid_nxt = 1'b1;
        char_nxt  = CH_MINUS;
        state_nxt = ST_INT;
      end
      ST_INT: begin
        valid_nxt = 1'b1;
        char_nxt  = CH_ZERO + {4'd0, int_digit};
        if (idx_r == '0) begin
          if (d_r == 3'd0) begin
            last_nxt  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_POINT;
          end
        end else begin
          idx_nxt = idx_r - 1'b1;
        end
      end
      ST_POINT: begin
        valid_nxt = 1'b1;
        char_nxt  = CH_POINT;
        cnt_nxt   = 3'd0;
        state_nxt = ST_FRAC;
      end
      ST_FRAC: begin
        valid_nxt = 1'b1;
        char_nxt  = CH_ZERO + {4'd0, frac_digit};
        frac_step = 1'b1;
        cnt_nxt   = cnt_inc;
        if (cnt_inc == d_r) begin
          last_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      frac_digits_r <= FRACTION_DIGITS_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= valid_nxt;
      if (cfg_valid && cfg_ready) begin
        frac_digits_r <= cfg_fraction_digits;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    cnt_r      <= cnt_nxt;
    out_char_r <= char_nxt;
    out_last_r <= last_nxt;
    out_ovf_r  <= ovf_r;
    if (accept) begin
      neg_r <= in_value_bits[31] && !is_nan && !is_zero;
      ovf_r <= sat;
      d_r   <= d_eff;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;
  assign out_overflow  = out_ovf_r;

  `F2FD_ASSERT_IMP(a_busy_mid_text, clk, rst_n, out_valid && !out_last, busy)
  `F2FD_ASSERT_IMP(a_idle_after_last, clk, rst_n, out_valid && out_last, !busy)
  `F2FD_ASSERT_NXT(a_start_takes, clk, rst_n, accept, busy && !out_valid)
  `F2FD_ASSERT_IMP(a_char_legal, clk, rst_n, out_valid,
    (out_character == CH_MINUS) || (out_character == CH_POINT) ||
    ((out_character >= CH_ZERO) && (out_character <= CH_ZERO + 8'd9)))

endmodule

// ===== rtl/f2fd_bcd_conv.sv =====
// ----------------------------------------------------------------------------
// f2fd_bcd_conv
// Bit-serial binary to BCD converter (shift and add three), one bit a cycle.
// ----------------------------------------------------------------------------
module f2fd_bcd_conv (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           load,
  input  logic [f2fd_pkg::IPART_W-1:0]   bin_in,
  input  logic [f2fd_pkg::DIG_IDX_W-1:0] sel,
  output logic [3:0]                     digit,
  output f2fd_pkg::f2fd_bcd_status_t     status
);
  import f2fd_pkg::*;

  localparam int CNT_W = $clog2(IPART_W + 1);

  logic [DIGITS-1:0][3:0] bcd_r, bcd_nxt;
  logic [IPART_W-1:0]     bin_r, bin_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [DIGITS*4-1:0]    adj;
  logic [DIG_IDX_W-1:0]   top;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      adj[i*4 +: 4] = (bcd_r[i] >= 4'd5) ? 4'(bcd_r[i] + 4'd3) : bcd_r[i];
    end
  end

  always_comb begin
    bcd_nxt = bcd_r;
    bin_nxt = bin_r;
    cnt_nxt = cnt_r;
    if (load) begin
      bcd_nxt = '0;
      bin_nxt = bin_in;
      cnt_nxt = CNT_W'(IPART_W);
    end else if (cnt_r != '0) begin
      bcd_nxt = {adj[DIGITS*4-2:0], bin_r[IPART_W-1]};
      bin_nxt = {bin_r[IPART_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bcd_r <= bcd_nxt;
    bin_r <= bin_nxt;
  end

  always_comb begin
    top = '0;
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_r[i] != 4'd0) begin
        top = DIG_IDX_W'(i);
      end
    end
  end

  assign digit          = bcd_r[sel];
  assign status.done    = (cnt_r == '0);
  assign status.top_idx = top;

endmodule

// ===== rtl/f2fd_frac_gen.sv =====
// ----------------------------------------------------------------------------
// f2fd_frac_gen
// Fraction digit generator: one decimal digit per step by times-ten.
// ----------------------------------------------------------------------------
module f2fd_frac_gen (
  input  logic                           clk,
  input  logic                           load,
  input  logic                           step,
  input  logic [f2fd_pkg::FRAC_BITS-1:0] frac_in,
  output logic [3:0]                     digit
);
  import f2fd_pkg::*;

  logic [FRAC_BITS-1:0]   frac_r;
  logic [FRAC_BITS+3:0]   prod;

  assign prod  = {1'b0, frac_r, 3'b000} + {3'b000, frac_r, 1'b0};
  assign digit = prod[FRAC_BITS+3:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (load) begin
      frac_r <= frac_in;
    end else if (step) begin
      frac_r <= prod[FRAC_BITS-1:0];
    end
  end

endmodule

// ===== verif/float_to_fixed_decimal_text_unit_tb.sv =====
// ----------------------------------------------------------------------------
// float_to_fixed_decimal_text_unit_tb
// Self-checking bench for the float to fixed decimal text unit. Sends single
// precision bit patterns through the start/busy port, predicts the full
// character stream of each number and compares every strobed character,
// last flag and overflow flag in order. Covers signed zeros, subnormals,
// saturation, NaN and infinity, every fraction digit setting, and random
// values with random gaps on the input and configuration ports.
// ----------------------------------------------------------------------------
module float_to_fixed_decimal_text_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import f2fd_pkg::*;

  localparam int unsigned UNIT_EXP = 150;
  localparam int unsigned MISMATCH_REPORTS = 10;
  localparam int unsigned DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
    logic       overflow;
  } text_char_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_value_bits = '0;
  logic        out_valid;
  logic [7:0]  out_character;
  logic        out_last;
  logic        out_overflow;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_fraction_digits = '0;

  text_char_t  pending_chars[$];
  logic [2:0]  fraction_digits_cfg;
  bit          no_gaps;
  int unsigned mismatch_count;
  int unsigned chars_checked;
  int unsigned numbers_sent;
  int unsigned overflow_numbers;
  int unsigned cfg_writes;

  float_to_fixed_decimal_text_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_value_bits       (in_value_bits),
    .out_valid           (out_valid),
    .out_character       (out_character),
    .out_last            (out_last),
    .out_overflow        (out_overflow),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_fraction_digits (cfg_fraction_digits)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void format_number_text(input logic [31:0] bits,
                                             input logic [2:0] digits_setting);
    logic        sign;
    logic [7:0]  bexp;
    logic [22:0] man;
    logic [63:0] signif;
    logic [63:0] ipart;
    logic [63:0] fval;
    logic [63:0] frac;
    logic [63:0] scale;
    logic        ovf;
    logic        is_nan;
    logic        is_zero;
    int unsigned d;
    int unsigned e;
    int unsigned sh;
    int unsigned nd;
    int unsigned digs[12];
    logic [7:0]  chars[$];
    text_char_t  tc;

    sign    = bits[31];
    bexp    = bits[30:23];
    man     = bits[22:0];
    is_nan  = (bexp == 8'hFF) && (man != '0);
    is_zero = (bexp == 8'h00) && (man == '0);
    ovf     = 1'b0;
    d       = 32'((digits_setting > MAX_FRACTION_DIGITS) ?
                  MAX_FRACTION_DIGITS : digits_setting);
    scale   = 64'd1;
    repeat (d) scale = scale * 64'd10;

    if (bexp >= SAT_EXP) begin
      ovf   = 1'b1;
      ipart = 64'(SAT_INTEGER);
      fval  = '0;
    end else begin
      signif = (bexp == 8'h00) ? 64'(man) : 64'({1'b1, man});
      e      = (bexp == 8'h00) ? 32'd1 : 32'(bexp);
      if (e >= UNIT_EXP) begin
        ipart = signif << (e - UNIT_EXP);
        fval  = '0;
      end else begin
        sh = UNIT_EXP - e;
        if (sh >= 64) begin
          ipart = '0;
          fval  = '0;
        end else begin
          frac  = signif & ((64'd1 << sh) - 64'd1);
          ipart = signif >> sh;
          fval  = (frac * scale) >> sh;
        end
      end
    end

    if (sign && !is_nan && !is_zero) chars.push_back(CH_MINUS);

    nd = 0;
    do begin
      digs[nd] = 32'(ipart % 64'd10);
      ipart    = ipart / 64'd10;
      nd++;
    end while (ipart != 0 && nd < 10);
    while (nd > 0) begin
      nd--;
      chars.push_back(CH_ZERO + 8'(digs[nd]));
    end

    if (d != 0) begin
      chars.push_back(CH_POINT);
      for (int unsigned i = 0; i < d; i++) begin
        digs[i] = 32'(fval % 64'd10);
        fval    = fval / 64'd10;
      end
      for (int unsigned i = d; i > 0; i--) chars.push_back(CH_ZERO + 8'(digs[i-1]));
    end

    foreach (chars[i]) begin
      tc.character = chars[i];
      tc.last      = (i == chars.size() - 1);
      tc.overflow  = ovf;
      pending_chars.push_back(tc);
    end
    if (ovf) overflow_numbers++;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] random_float();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0, 1:    ;
      2, 3, 4: v[30:23] = 8'($urandom_range(100, 160));
      5:       v[30:23] = 8'($urandom_range(150, 158));
      6:       v[30:23] = 8'h00;
      7:       v[30:23] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      8:       v[30:0]  = {8'($urandom_range(118, 131)), 23'($urandom_range(0, 15)) << 19};
      default: v[30:23] = 8'($urandom_range(0, 40));
    endcase
    return v;
  endfunction

  task automatic send_number(input logic [31:0] bits);
    int unsigned gap;
    start         <= 1'b1;
    in_value_bits <= bits;
    do @(posedge clk); while (busy);
    format_number_text(bits, fraction_digits_cfg);
    numbers_sent++;
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_outputs();
    start <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_fraction_digits(input logic [2:0] digits);
    drain_outputs();
    repeat ($urandom_range(0, 5)) @(posedge clk);
    cfg_valid           <= 1'b1;
    cfg_fraction_digits <= digits;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid           <= 1'b0;
    fraction_digits_cfg = digits;
    cfg_writes++;
  endtask

  always @(posedge clk) begin
    text_char_t exp_c;
    if (rst_n && out_valid) begin
      chars_checked++;
      if (pending_chars.size() == 0) begin
        if (mismatch_count < MISMATCH_REPORTS)
          $display("unexpected character %h last %b ovf %b at %0t",
                   out_character, out_last, out_overflow, $realtime);
        mismatch_count++;
      end else begin
        exp_c = pending_chars.pop_front();
        if (out_character !== exp_c.character || out_last !== exp_c.last ||
            out_overflow !== exp_c.overflow) begin
          if (mismatch_count < MISMATCH_REPORTS)
            $display("char mismatch at %0t: exp %h/%b/%b got %h/%b/%b", $realtime,
                     exp_c.character, exp_c.last, exp_c.overflow,
                     out_character, out_last, out_overflow);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_special_values();
    logic [31:0] specials[$];
    specials = {32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBFC0_0000,
                32'h0000_0001, 32'h8000_0001, 32'h007F_FFFF, 32'h3DCC_CCCD,
                32'h42F6_E979, 32'h3F7F_FFFF, 32'h4B00_0000, 32'h4EFF_FFFF,
                32'h4F00_0000, 32'hCF00_0000, 32'h7F80_0000, 32'hFF80_0000,
                32'hFFFF_FFFF, 32'h7F7F_FFFF};
    foreach (specials[i]) send_number(specials[i]);
    drain_outputs();
  endtask

  task automatic test_fraction_digit_sweep();
    for (int d = 0; d <= 7; d++) begin
      set_fraction_digits(3'(d));
      send_number((d % 2 == 0) ? 32'hC2F6_E979 : 32'h3EAA_AAAB);
    end
    drain_outputs();
  endtask

  task automatic test_random_values();
    logic [2:0] phase_digits[5];
    phase_digits = '{3'd0, 3'd6, 3'd7, 3'($urandom_range(1, 5)), 3'($urandom_range(0, 7))};
    foreach (phase_digits[p]) begin
      set_fraction_digits(phase_digits[p]);
      no_gaps = (p == 2);
      repeat (40) send_number(random_float());
    end
    no_gaps = 1'b0;
    drain_outputs();
  endtask

  initial begin
    fraction_digits_cfg = FRACTION_DIGITS_RESET;
    no_gaps             = 1'b0;
    mismatch_count      = 0;
    chars_checked       = 0;
    numbers_sent        = 0;
    overflow_numbers    = 0;
    cfg_writes          = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_special_values();
    test_fraction_digit_sweep();
    test_random_values();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_chars.size() != 0) begin
      $display("%0d expected characters never arrived", pending_chars.size());
      mismatch_count++;
    end
    $display("Sent %0d numbers (%0d saturated) over %0d fraction digit writes,",
             numbers_sent, overflow_numbers, cfg_writes);
    $display("checked %0d characters, %0d mismatches.", chars_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout waiting for transfers");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/f2fd_pkg.sv
rtl/f2fd_bcd_conv.sv
rtl/f2fd_frac_gen.sv
rtl/float_to_fixed_decimal_text_unit.sv
verif/float_to_fixed_decimal_text_unit_tb.sv
